[rtl/core/prid_pkg.sv]
// Package for the palette run-length icon decoder core.
// Holds parse phase, status codes, queue entry type and blend helpers.
// No dependencies.
package prid_pkg;

    typedef enum logic [2:0] {
        PH_HDR     = 3'd0,
        PH_PAL     = 3'd1,
        PH_CNT     = 3'd2,
        PH_RUNIDX  = 3'd3,
        PH_LITCNT  = 3'd4,
        PH_LITDATA = 3'd5,
        PH_ERR     = 3'd6
    } phase_t;

    localparam logic [3:0] ST_OK       = 4'd0;
    localparam logic [3:0] ST_VERSION  = 4'd1;
    localparam logic [3:0] ST_GEOMETRY = 4'd2;
    localparam logic [3:0] ST_PALLEN   = 4'd3;
    localparam logic [3:0] ST_TRUNC    = 4'd4;
    localparam logic [3:0] ST_INDEX    = 4'd5;
    localparam logic [3:0] ST_OVERFLOW = 4'd6;
    localparam logic [3:0] ST_EMPTYLIT = 4'd7;
    localparam logic [3:0] ST_SHORT    = 4'd8;

    localparam logic [1:0] CFG_VERSION = 2'd0;
    localparam logic [1:0] CFG_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_HEIGHT  = 2'd2;
    localparam logic [1:0] CFG_BG      = 2'd3;

    // Work item passed from the front to the back.
    typedef struct packed {
        logic        wr_pal;     // store a palette entry
        logic [3:0]  wr_addr;
        logic [15:0] wr_color;
        logic        px_a;       // first pixel (run or high nibble)
        logic [3:0]  idx_a;
        logic [7:0]  cnt_a;
        logic        px_b;       // second literal pixel (low nibble)
        logic [3:0]  idx_b;
        logic        stat;       // closing status item
        logic [3:0]  code;
    } work_t;

    // Widen a 5-bit channel to 8 bits by bit replication.
    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        widen6 = {v, v[5:4]};
    endfunction

endpackage

[rtl/core/prid_blend.sv]
// Registered blend of one channel: (s*a + d*(255-a) + 127) / 255.
// Depends on nothing; division by 255 done with a reciprocal and correction.
module prid_blend
(
    input  logic       clk,
    input  logic [7:0] s,
    input  logic [7:0] d,
    input  logic [7:0] a,
    output logic [7:0] q
);
    logic [16:0] sum_reg;
    logic [16:0] sum_next;
    logic [16:0] quo;
    logic [16:0] rem;

    // Products summed and registered before the division.
    assign sum_next = 17'(s * a) + 17'(d * (8'd255 - a)) + 17'd127;

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
    end

    // x/255 approximated by (x + x>>8 + 1) >> 8, then one correction step.
    always_comb
    begin
        quo = (sum_reg + (sum_reg >> 8) + 17'd1) >> 8;
        rem = sum_reg - 17'(quo * 17'd255);
        if (rem[16])
        begin
            quo = quo - 17'd1;
        end
    end

    assign q = quo[7:0];
endmodule

[rtl/core/prid_front.sv]
// Front part: parses the blob byte stream, checks header and counts,
// resolves palette entries and issues work items. Depends on prid_pkg, prid_blend.
module prid_front
#(
    parameter int PALETTE_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       blob_byte,
    input  logic             blob_end,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       expected_version,
    input  logic [7:0]       icon_width,
    input  logic [7:0]       icon_height,
    input  logic [15:0]      background_color,
    output logic             q_valid,
    output prid_pkg::work_t  q_data,
    input  logic             q_ready
);
    prid_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  bc_reg, bc_next;
    logic [4:0]  plen_reg, plen_next;
    logic [4:0]  ploaded_reg, ploaded_next;
    logic [15:0] ecol_reg, ecol_next;
    logic [15:0] written_reg, written_next;
    logic [15:0] total_reg, total_next;
    logic [7:0]  runcnt_reg, runcnt_next;
    logic [7:0]  litrem_reg, litrem_next;
    logic [3:0]  err_reg, err_next;

    // Blend pipeline stage: entry waits for the registered channel results.
    logic        bl_pend_reg;
    logic [3:0]  bl_addr_reg;
    logic [15:0] bl_raw_reg;
    logic        bl_opaque_reg;
    logic        bl_stat_reg;
    logic [3:0]  bl_code_reg;
    logic [7:0]  r8, g8, b8;

    logic        accept;
    logic        hold_valid_reg;
    prid_pkg::work_t w;
    logic        pal_wr;
    logic        end_stat;
    logic [3:0]  end_code;
    logic [16:0] sum_run;
    logic [16:0] sum_lit;
    logic        fail;
    logic [3:0]  fail_code;

    // Accept while the work register is empty or being drained, and no
    // blended entry is waiting.
    assign in_ready = (!hold_valid_reg || q_ready) && !bl_pend_reg;
    assign accept   = in_valid && in_ready;

    prid_blend u_r (.clk(clk), .s(prid_pkg::widen5(ecol_reg[15:11])),
        .d(prid_pkg::widen5(background_color[15:11])), .a(blob_byte), .q(r8));
    prid_blend u_g (.clk(clk), .s(prid_pkg::widen6(ecol_reg[10:5])),
        .d(prid_pkg::widen6(background_color[10:5])), .a(blob_byte), .q(g8));
    prid_blend u_b (.clk(clk), .s(prid_pkg::widen5(ecol_reg[4:0])),
        .d(prid_pkg::widen5(background_color[4:0])), .a(blob_byte), .q(b8));

    assign sum_run = {1'b0, written_reg} + {9'd0, runcnt_reg};
    assign sum_lit = {1'b0, written_reg} + {9'd0, blob_byte};

    // Parse one byte.
    always_comb
    begin
        phase_next   = phase_reg;
        bc_next      = bc_reg;
        plen_next    = plen_reg;
        ploaded_next = ploaded_reg;
        ecol_next    = ecol_reg;
        written_next = written_reg;
        total_next   = total_reg;
        runcnt_next  = runcnt_reg;
        litrem_next  = litrem_reg;
        err_next     = err_reg;
        w            = '0;
        pal_wr       = 1'b0;
        fail         = 1'b0;
        fail_code    = prid_pkg::ST_OK;
        end_stat     = 1'b0;
        end_code     = prid_pkg::ST_OK;

        case (phase_reg)
            prid_pkg::PH_HDR:
            begin
                case (bc_reg)
                    2'd0:
                    begin
                        if (blob_byte != expected_version)
                        begin
                            fail = 1'b1; fail_code = prid_pkg::ST_VERSION;
                        end
                    end
                    2'd1:
                    begin
                        if (blob_byte != icon_width)
                        begin
                            fail = 1'b1; fail_code = prid_pkg::ST_GEOMETRY;
                        end
                    end
                    2'd2:
                    begin
                        if (blob_byte != icon_height)
                        begin
                            fail = 1'b1; fail_code = prid_pkg::ST_GEOMETRY;
                        end
                    end
                    default:
                    begin
                        if (blob_byte == 8'd0 || blob_byte > 8'(PALETTE_DEPTH))
                        begin
                            fail = 1'b1; fail_code = prid_pkg::ST_PALLEN;
                        end
                        else
                        begin
                            plen_next  = blob_byte[4:0];
                            total_next = icon_width * icon_height;
                            phase_next = prid_pkg::PH_PAL;
                        end
                    end
                endcase
                bc_next = bc_reg + 2'd1;
            end
            prid_pkg::PH_PAL:
            begin
                if (bc_reg == 2'd0)
                begin
                    ecol_next = {8'd0, blob_byte};
                    bc_next   = 2'd1;
                end
                else if (bc_reg == 2'd1)
                begin
                    ecol_next = {blob_byte, ecol_reg[7:0]};
                    bc_next   = 2'd2;
                end
                else
                begin
                    pal_wr       = 1'b1;
                    ploaded_next = ploaded_reg + 5'd1;
                    bc_next      = 2'd0;
                    if (ploaded_next >= plen_reg)
                    begin
                        phase_next = prid_pkg::PH_CNT;
                    end
                end
            end
            prid_pkg::PH_CNT:
            begin
                if (blob_byte != 8'd0)
                begin
                    runcnt_next = blob_byte;
                    phase_next  = prid_pkg::PH_RUNIDX;
                end
                else
                begin
                    phase_next = prid_pkg::PH_LITCNT;
                end
            end
            prid_pkg::PH_RUNIDX:
            begin
                if ({3'd0, blob_byte} >= plen_reg)
                begin
                    fail = 1'b1; fail_code = prid_pkg::ST_INDEX;
                end
                else if (sum_run > {1'b0, total_reg})
                begin
                    fail = 1'b1; fail_code = prid_pkg::ST_OVERFLOW;
                end
                else
                begin
                    w.px_a       = 1'b1;
                    w.idx_a      = blob_byte[3:0];
                    w.cnt_a      = runcnt_reg;
                    written_next = sum_run[15:0];
                    phase_next   = prid_pkg::PH_CNT;
                end
            end
            prid_pkg::PH_LITCNT:
            begin
                if (blob_byte == 8'd0)
                begin
                    fail = 1'b1; fail_code = prid_pkg::ST_EMPTYLIT;
                end
                else if (sum_lit > {1'b0, total_reg})
                begin
                    fail = 1'b1; fail_code = prid_pkg::ST_OVERFLOW;
                end
                else
                begin
                    litrem_next = blob_byte;
                    phase_next  = prid_pkg::PH_LITDATA;
                end
            end
            prid_pkg::PH_LITDATA:
            begin
                if ({1'b0, blob_byte[7:4]} >= plen_reg)
                begin
                    fail = 1'b1; fail_code = prid_pkg::ST_INDEX;
                end
                else
                begin
                    w.px_a = 1'b1; w.idx_a = blob_byte[7:4]; w.cnt_a = 8'd1;
                    written_next = written_reg + 16'd1;
                    litrem_next  = litrem_reg - 8'd1;
                    if (litrem_next != 8'd0)
                    begin
                        if ({1'b0, blob_byte[3:0]} >= plen_reg)
                        begin
                            fail = 1'b1; fail_code = prid_pkg::ST_INDEX;
                        end
                        else
                        begin
                            w.px_b = 1'b1; w.idx_b = blob_byte[3:0];
                            written_next = written_reg + 16'd2;
                            litrem_next  = litrem_reg - 8'd2;
                        end
                    end
                    if (!fail && litrem_next == 8'd0)
                    begin
                        phase_next = prid_pkg::PH_CNT;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (fail)
        begin
            phase_next = prid_pkg::PH_ERR;
            if (err_reg == prid_pkg::ST_OK)
            begin
                err_next = fail_code;
            end
        end

        // Closing status item and parser clear.
        if (blob_end)
        begin
            end_stat = 1'b1;
            if (err_next != prid_pkg::ST_OK)
            begin
                end_code = err_next;
            end
            else if (phase_next != prid_pkg::PH_CNT)
            begin
                end_code = prid_pkg::ST_TRUNC;
            end
            else if (written_next == total_next)
            begin
                end_code = prid_pkg::ST_OK;
            end
            else
            begin
                end_code = prid_pkg::ST_SHORT;
            end
            phase_next   = prid_pkg::PH_HDR;
            bc_next      = 2'd0;
            plen_next    = 5'd0;
            ploaded_next = 5'd0;
            ecol_next    = 16'd0;
            written_next = 16'd0;
            total_next   = 16'd0;
            runcnt_next  = 8'd0;
            litrem_next  = 8'd0;
            err_next     = prid_pkg::ST_OK;
        end
        w.stat = end_stat;
        w.code = end_code;
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= prid_pkg::PH_HDR;
            bc_reg         <= 2'd0;
            plen_reg       <= 5'd0;
            ploaded_reg    <= 5'd0;
            ecol_reg       <= 16'd0;
            written_reg    <= 16'd0;
            total_reg      <= 16'd0;
            runcnt_reg     <= 8'd0;
            litrem_reg     <= 8'd0;
            err_reg        <= prid_pkg::ST_OK;
            bl_pend_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg   <= phase_next;
                bc_reg      <= bc_next;
                plen_reg    <= plen_next;
                ploaded_reg <= ploaded_next;
                ecol_reg    <= ecol_next;
                written_reg <= written_next;
                total_reg   <= total_next;
                runcnt_reg  <= runcnt_next;
                litrem_reg  <= litrem_next;
                err_reg     <= err_next;
            end
            bl_pend_reg <= accept && pal_wr;
            if (accept && !pal_wr)
            begin
                hold_valid_reg <= w.px_a || w.stat;
            end
            else if (bl_pend_reg)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (q_ready)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Work item register and pending palette entry.
    prid_pkg::work_t q_reg;
    prid_pkg::work_t pal_item;
    logic [15:0] blended;
    assign blended = bl_opaque_reg ? bl_raw_reg : {r8[7:3], g8[7:2], b8[7:3]};

    always_comb
    begin
        pal_item          = '0;
        pal_item.wr_pal   = 1'b1;
        pal_item.wr_addr  = bl_addr_reg;
        pal_item.wr_color = blended;
        pal_item.stat     = bl_stat_reg;
        pal_item.code     = bl_code_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && pal_wr)
        begin
            bl_addr_reg   <= ploaded_reg[3:0];
            bl_raw_reg    <= ecol_reg;
            bl_opaque_reg <= (blob_byte == 8'd255);
            bl_stat_reg   <= end_stat;
            bl_code_reg   <= end_code;
        end
        if (accept && !pal_wr)
        begin
            q_reg <= w;
        end
        else if (bl_pend_reg)
        begin
            q_reg <= pal_item;
        end
    end

    assign q_valid = hold_valid_reg;
    assign q_data  = q_reg;

    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == prid_pkg::PH_PAL |-> plen_reg != 5'd0)
        else $error("palette phase with zero length");
    a_blend_stall: assert property (@(posedge clk) disable iff (!rst_n)
        bl_pend_reg |-> !in_ready)
        else $error("byte accepted while palette entry pending");
    a_written: assert property (@(posedge clk) disable iff (!rst_n)
        written_reg <= total_reg)
        else $error("pixel count past icon size");
endmodule

[rtl/core/prid_back.sv]
// Back part: palette store and emission of pixel and status beats.
// Depends on prid_pkg.
module prid_back
#(
    parameter int PALETTE_DEPTH = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  prid_pkg::work_t q_data,
    output logic            q_ready,
    output logic            o_valid,
    output logic [15:0]     o_color,
    output logic [7:0]      o_count,
    output logic            o_done,
    output logic [3:0]      o_code,
    input  logic            o_ready
);
    logic [15:0] pal_reg [PALETTE_DEPTH];
    // Work item being emitted; step counts beats already sent.
    prid_pkg::work_t cur_reg;
    logic        busy_reg;
    logic [1:0]  step_reg;
    logic [1:0]  nbeats;
    logic        last_beat;
    logic [1:0]  sel;
    logic        ovalid;

    assign nbeats = 2'(cur_reg.px_a) + 2'(cur_reg.px_b) + 2'(cur_reg.stat);
    // Beat kind: 0 first pixel, 1 second pixel, 2 status.
    always_comb
    begin
        sel = 2'd2;
        if (step_reg == 2'd0 && cur_reg.px_a)
        begin
            sel = 2'd0;
        end
        else if (cur_reg.px_b && (step_reg == 2'd1))
        begin
            sel = 2'd1;
        end
    end
    assign ovalid    = busy_reg && nbeats != 2'd0;
    assign last_beat = (step_reg + 2'd1 >= nbeats);
    assign q_ready   = !busy_reg || nbeats == 2'd0 || (o_ready && last_beat);

    always_comb
    begin
        o_color = 16'd0;
        o_count = 8'd0;
        o_done  = 1'b0;
        o_code  = prid_pkg::ST_OK;
        case (sel)
            2'd0:
            begin
                o_color = pal_reg[cur_reg.idx_a[$clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2)-1:0]];
                o_count = cur_reg.cnt_a;
            end
            2'd1:
            begin
                o_color = pal_reg[cur_reg.idx_b[$clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2)-1:0]];
                o_count = 8'd1;
            end
            default:
            begin
                o_done = 1'b1;
                o_code = cur_reg.code;
            end
        endcase
    end
    assign o_valid = ovalid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
        end
        else if (q_valid && q_ready)
        begin
            busy_reg <= 1'b1;
            step_reg <= 2'd0;
        end
        else if (ovalid && o_ready)
        begin
            step_reg <= step_reg + 2'd1;
            if (last_beat)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid && q_ready)
        begin
            cur_reg <= q_data;
            if (q_data.wr_pal)
            begin
                pal_reg[q_data.wr_addr[$clog2(PALETTE_DEPTH > 1 ? PALETTE_DEPTH : 2)-1:0]]
                    <= q_data.wr_color;
            end
        end
    end

    a_beats: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= nbeats)
        else $error("beat count beyond work item");
    a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid && o_done) |-> last_beat)
        else $error("status beat not last");
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (o_valid && o_done) |-> (o_count == 8'd0 && o_color == 16'd0))
        else $error("status beat carries pixel data");
endmodule

[rtl/core/palette_rle_icon_decoder_core.sv]
// Palette run-length icon decoder: one blob byte per beat in, colour runs
// and a closing status beat out. Takes one byte per cycle while the work
// register drains and no palette entry waits in the blend stage; a literal
// byte with two pixels gives one output beat per pixel.
// Asynchronous active-low reset returns the parser to the header and the
// registers to version 1, 32 by 32, black background; palette reads undefined.
module palette_rle_icon_decoder_core
#(
    parameter int PALETTE_DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] blob_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] pixel_color, [23:16] repeat_count,
                                        // [27:24] status_code
    output logic        m_axis_tlast,   // done_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    logic [7:0]  ver_reg, wid_reg, hgt_reg;
    logic [15:0] bg_reg;
    logic        q_valid, q_ready;
    prid_pkg::work_t q_data;
    logic [15:0] color;
    logic [7:0]  count;
    logic [3:0]  code;

    // Configuration registers.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ver_reg <= 8'd1;
            wid_reg <= 8'd32;
            hgt_reg <= 8'd32;
            bg_reg  <= 16'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                prid_pkg::CFG_VERSION: ver_reg <= cfg_data[7:0];
                prid_pkg::CFG_WIDTH:   wid_reg <= cfg_data[7:0];
                prid_pkg::CFG_HEIGHT:  hgt_reg <= cfg_data[7:0];
                default:               bg_reg  <= cfg_data;
            endcase
        end
    end

    prid_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .blob_byte(s_axis_tdata), .blob_end(s_axis_tlast),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .expected_version(ver_reg), .icon_width(wid_reg),
        .icon_height(hgt_reg), .background_color(bg_reg),
        .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready));

    prid_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_data(q_data), .q_ready(q_ready),
        .o_valid(m_axis_tvalid), .o_color(color), .o_count(count),
        .o_done(m_axis_tlast), .o_code(code), .o_ready(m_axis_tready));

    assign m_axis_tdata = {4'd0, code, count, color};
endmodule
